/* hdl/ffsa_pkg.sv */
// shared types and constants for the first-fit segment allocator
package ffsa_pkg;

  localparam int SIZE_W = 24;
  localparam int PCT_W = 7;
  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_HEADER_BYTES = 20;
  localparam int SPLIT_SLACK = 64;
  localparam logic [SIZE_W-1:0] REGION_RESET = 24'd65536;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FIT       = 2'd1,
    ST_NOT_BASE     = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_NEXT_RD,
    S_NEXT_EV,
    S_MERGE,
    S_WR_CUR,
    S_MV_RD,
    S_MV_WR,
    S_WR_TAIL,
    S_USE_RD,
    S_USE_EV,
    S_DIV_GO,
    S_DIV_WAIT
  } seq_state_e;

  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
  } seg_entry_t;

endpackage

/* hdl/ffsa_table.sv */
// segment table memory, one write and one registered read per cycle
module ffsa_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  ffsa_pkg::seg_entry_t wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output ffsa_pkg::seg_entry_t rdata_o
);
  import ffsa_pkg::*;

  seg_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hdl/ffsa_div.sv */
// restoring divider for the usage percentage, one quotient bit per cycle
module ffsa_div #(
  parameter int DEN_W = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [DEN_W+ffsa_pkg::PCT_W-1:0]  num_i,
  input  logic [DEN_W-1:0]                  den_i,
  output logic                              done_o,
  output logic [ffsa_pkg::PCT_W-1:0]        quot_o
);
  import ffsa_pkg::*;

  localparam int NUM_W  = DEN_W + PCT_W;
  localparam int STEP_W = $clog2(PCT_W);

  logic [NUM_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [PCT_W-1:0]  quot_q, quot_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              run_q, run_d;
  logic              done_q, done_d;
  logic              zero_q, zero_d;
  logic [NUM_W-1:0]  trial;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
    step_q <= step_d;
    zero_q <= zero_d;
  end

  // one trial subtraction per cycle
  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    step_d = step_q;
    zero_d = zero_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = NUM_W'(den_q) << step_q;
    if (start_i) begin
      rem_d  = num_i;
      den_d  = den_i;
      quot_d = '0;
      step_d = STEP_W'(PCT_W - 1);
      zero_d = (den_i == '0);
      run_d  = 1'b1;
    end else if (run_q) begin
      if (rem_q >= trial) begin
        rem_d          = rem_q - trial;
        quot_d[step_q] = 1'b1;
      end
      if (step_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - STEP_W'(1);
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = zero_q ? '0 : quot_q;

endmodule

/* hdl/first_fit_segment_allocator_core.sv */
// first-fit segment allocator top level: sequencer over the segment table
// A request (allocate or free) is taken when start_i is high and busy_o is low,
// and its result is shown for exactly one cycle with result_valid_o; the
// receiver cannot stall it. One request runs a table scan up to the segment
// reached, moves one entry at a time when a segment is split or merged away,
// walks all segments afterwards to sum usage and ends with the percentage
// divide; the sequencer reads each entry through the registered read of the
// segment table and examines it in a separate state. busy_o stays high for
// the whole request. A write of region_bytes (only while idle) rebuilds the
// table as one free segment at once, with no clearing pass.
module first_fit_segment_allocator_core #(
  parameter int MAX_SEGMENTS = ffsa_pkg::DEF_MAX_SEGMENTS,
  parameter int HEADER_BYTES = ffsa_pkg::DEF_HEADER_BYTES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ffsa_pkg::SIZE_W-1:0]      cfg_wdata_i,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             action_i,
  input  logic [ffsa_pkg::SIZE_W-1:0]      request_bytes_i,
  input  logic [ffsa_pkg::SIZE_W-1:0]      release_offset_i,
  output logic                             result_valid_o,
  output logic [1:0]                       status_o,
  output logic [ffsa_pkg::SIZE_W-1:0]      granted_offset_o,
  output logic [ffsa_pkg::PCT_W-1:0]       usage_percent_o
);
  import ffsa_pkg::*;

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int ACC_W = SIZE_W + 1 + CNT_W;
  localparam int NUM_W = ACC_W + PCT_W;
  localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] SPLIT_LIM = SIZE_W'(HEADER_BYTES + SPLIT_SLACK);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

  seq_state_e        state_q, state_d;
  logic [SIZE_W-1:0] region_q, region_d;
  logic              init_q, init_d;
  logic              rd_init_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [SIZE_W-1:0] pos_q, pos_d;
  logic              op_q, op_d;
  logic [SIZE_W-1:0] want_q, want_d;
  logic [SIZE_W-1:0] offset_q, offset_d;
  logic [SIZE_W-1:0] cur_sz_q, cur_sz_d;
  logic [SIZE_W-1:0] prev_sz_q, prev_sz_d;
  logic              prev_used_q, prev_used_d;
  logic [SIZE_W-1:0] next_sz_q, next_sz_d;
  logic              next_free_q, next_free_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic              split_q, split_d;
  logic [CNT_W-1:0]  src_q, src_d;
  logic [CNT_W-1:0]  dst_q, dst_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic              mv_up_q, mv_up_d;
  logic [ACC_W-1:0]  used_sum_q, used_sum_d;
  logic [ACC_W-1:0]  all_sum_q, all_sum_d;
  status_e           status_q, status_d;
  logic [SIZE_W-1:0] granted_q, granted_d;
  logic [PCT_W-1:0]  usage_q, usage_d;
  logic              valid_q, valid_d;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  seg_entry_t        mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  seg_entry_t        mem_rdata;
  seg_entry_t        ent;
  seg_entry_t        init_ent;
  logic              div_start;
  logic              div_done;
  logic [PCT_W-1:0]  div_quot;
  logic [NUM_W-1:0]  div_num;

  logic              enter_use;
  logic              nb_prev;
  logic              nb_next;
  logic [SIZE_W-1:0] sum1;
  logic [SIZE_W-1:0] sum2;
  logic [CNT_W-1:0]  rm_cnt;
  logic [CNT_W-1:0]  rm_base;
  logic [ACC_W-1:0]  ent_bytes;

  // segment table
  ffsa_table #(
    .DEPTH (MAX_SEGMENTS),
    .AW    (IDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // usage divider, used * 100 built from shifts
  assign div_num = (NUM_W'(used_sum_q) << 6) + (NUM_W'(used_sum_q) << 5)
                 + (NUM_W'(used_sum_q) << 2);

  ffsa_div #(
    .DEN_W (ACC_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (all_sum_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // entry 0 after a rebuild reads as one free segment until first written
  assign init_ent.used = 1'b0;
  assign init_ent.size = (region_q >= HDR) ? region_q - HDR : '0;
  assign ent = rd_init_q ? init_ent : mem_rdata;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      region_q  <= REGION_RESET;
      init_q    <= 1'b1;
      rd_init_q <= 1'b0;
      count_q   <= CNT_W'(1);
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      region_q  <= region_d;
      init_q    <= init_d;
      rd_init_q <= init_d && (mem_raddr == '0);
      count_q   <= count_d;
      valid_q   <= valid_d;
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    pos_q       <= pos_d;
    op_q        <= op_d;
    want_q      <= want_d;
    offset_q    <= offset_d;
    cur_sz_q    <= cur_sz_d;
    prev_sz_q   <= prev_sz_d;
    prev_used_q <= prev_used_d;
    next_sz_q   <= next_sz_d;
    next_free_q <= next_free_d;
    rem_q       <= rem_d;
    split_q     <= split_d;
    src_q       <= src_d;
    dst_q       <= dst_d;
    left_q      <= left_d;
    mv_up_q     <= mv_up_d;
    used_sum_q  <= used_sum_d;
    all_sum_q   <= all_sum_d;
    status_q    <= status_d;
    granted_q   <= granted_d;
    usage_q     <= usage_d;
  end

  // merge arithmetic for a free request
  always_comb begin
    nb_prev = (idx_q != '0) && !prev_used_q;
    nb_next = next_free_q;
    sum1    = nb_prev ? prev_sz_q + cur_sz_q + HDR : cur_sz_q;
    sum2    = nb_next ? sum1 + next_sz_q + HDR : sum1;
    rm_cnt  = CNT_W'(nb_prev) + CNT_W'(nb_next);
    rm_base = (nb_next && !nb_prev) ? idx_q + CNT_W'(1) : idx_q;
  end

  assign ent_bytes = ACC_W'(ent.size) + ACC_W'(HDR);

  // sequencer
  always_comb begin
    state_d     = state_q;
    region_d    = region_q;
    init_d      = init_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    op_d        = op_q;
    want_d      = want_q;
    offset_d    = offset_q;
    cur_sz_d    = cur_sz_q;
    prev_sz_d   = prev_sz_q;
    prev_used_d = prev_used_q;
    next_sz_d   = next_sz_q;
    next_free_d = next_free_q;
    rem_d       = rem_q;
    split_d     = split_q;
    src_d       = src_q;
    dst_d       = dst_q;
    left_d      = left_q;
    mv_up_d     = mv_up_q;
    used_sum_d  = used_sum_q;
    all_sum_d   = all_sum_q;
    status_d    = status_q;
    granted_d   = granted_q;
    usage_d     = usage_q;
    valid_d     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[IDX_W-1:0];
    mem_wdata   = ent;
    mem_raddr   = idx_q[IDX_W-1:0];
    div_start   = 1'b0;
    enter_use   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          region_d = cfg_wdata_i;
          init_d   = 1'b1;
          count_d  = CNT_W'(1);
        end
        if (start_i) begin
          op_d        = action_i;
          want_d      = request_bytes_i;
          offset_d    = release_offset_i;
          idx_d       = '0;
          pos_d       = HDR;
          prev_used_d = 1'b1;
          next_free_d = 1'b0;
          granted_d   = '0;
          status_d    = ST_OK;
          state_d     = S_SCAN_RD;
        end
      end

      S_SCAN_RD: begin
        state_d = S_SCAN_EV;
      end

      // examine one entry of the first-fit or offset search
      S_SCAN_EV: begin
        if (!op_q) begin
          if (!ent.used && (want_q <= ent.size)) begin
            cur_sz_d  = ent.size;
            granted_d = pos_q;
            rem_d     = ent.size - want_q;
            split_d   = ((ent.size - want_q) > SPLIT_LIM) && (count_q < CNT_MAX);
            state_d   = S_WR_CUR;
          end else begin
            pos_d = pos_q + ent.size + HDR;
            idx_d = idx_q + CNT_W'(1);
            if (idx_q + CNT_W'(1) == count_q) begin
              status_d  = ST_NO_FIT;
              enter_use = 1'b1;
            end else begin
              state_d = S_SCAN_RD;
            end
          end
        end else begin
          if (pos_q == offset_q) begin
            if (!ent.used) begin
              status_d  = ST_ALREADY_FREE;
              enter_use = 1'b1;
            end else begin
              cur_sz_d = ent.size;
              if (idx_q + CNT_W'(1) < count_q) begin
                state_d = S_NEXT_RD;
              end else begin
                next_free_d = 1'b0;
                state_d     = S_MERGE;
              end
            end
          end else begin
            prev_sz_d   = ent.size;
            prev_used_d = ent.used;
            pos_d       = pos_q + ent.size + HDR;
            idx_d       = idx_q + CNT_W'(1);
            if (idx_q + CNT_W'(1) == count_q) begin
              status_d  = ST_NOT_BASE;
              enter_use = 1'b1;
            end else begin
              state_d = S_SCAN_RD;
            end
          end
        end
      end

      S_NEXT_RD: begin
        mem_raddr = IDX_W'(idx_q + CNT_W'(1));
        state_d   = S_NEXT_EV;
      end

      S_NEXT_EV: begin
        next_sz_d   = ent.size;
        next_free_d = !ent.used;
        state_d     = S_MERGE;
      end

      // write the merged segment, then close the gap
      S_MERGE: begin
        mem_we         = 1'b1;
        mem_waddr      = nb_prev ? IDX_W'(idx_q - CNT_W'(1)) : idx_q[IDX_W-1:0];
        mem_wdata.used = 1'b0;
        mem_wdata.size = sum2;
        count_d        = count_q - rm_cnt;
        dst_d          = rm_base;
        src_d          = rm_base + rm_cnt;
        left_d         = count_q - rm_base - rm_cnt;
        mv_up_d        = 1'b0;
        if (rm_cnt == '0 || (count_q - rm_base - rm_cnt) == '0) begin
          enter_use = 1'b1;
        end else begin
          state_d = S_MV_RD;
        end
      end

      // mark the allocated segment, open a slot if it splits
      S_WR_CUR: begin
        mem_we         = 1'b1;
        mem_wdata.used = 1'b1;
        mem_wdata.size = split_q ? want_q : cur_sz_q;
        if (split_q) begin
          mv_up_d = 1'b1;
          dst_d   = count_q;
          src_d   = count_q - CNT_W'(1);
          left_d  = count_q - idx_q - CNT_W'(1);
          if (count_q - idx_q - CNT_W'(1) == '0) begin
            state_d = S_WR_TAIL;
          end else begin
            state_d = S_MV_RD;
          end
        end else begin
          enter_use = 1'b1;
        end
      end

      S_MV_RD: begin
        mem_raddr = src_q[IDX_W-1:0];
        state_d   = S_MV_WR;
      end

      // move one entry
      S_MV_WR: begin
        mem_we    = 1'b1;
        mem_waddr = dst_q[IDX_W-1:0];
        mem_wdata = ent;
        left_d    = left_q - CNT_W'(1);
        if (mv_up_q) begin
          src_d = src_q - CNT_W'(1);
          dst_d = dst_q - CNT_W'(1);
        end else begin
          src_d = src_q + CNT_W'(1);
          dst_d = dst_q + CNT_W'(1);
        end
        if (left_q == CNT_W'(1)) begin
          if (mv_up_q) begin
            state_d = S_WR_TAIL;
          end else begin
            enter_use = 1'b1;
          end
        end else begin
          state_d = S_MV_RD;
        end
      end

      // new free tail after a split
      S_WR_TAIL: begin
        mem_we         = 1'b1;
        mem_waddr      = IDX_W'(idx_q + CNT_W'(1));
        mem_wdata.used = 1'b0;
        mem_wdata.size = rem_q - HDR;
        count_d        = count_q + CNT_W'(1);
        enter_use      = 1'b1;
      end

      S_USE_RD: begin
        state_d = S_USE_EV;
      end

      // accumulate used and total bytes
      S_USE_EV: begin
        all_sum_d = all_sum_q + ent_bytes;
        if (ent.used) begin
          used_sum_d = used_sum_q + ent_bytes;
        end
        idx_d = idx_q + CNT_W'(1);
        if (idx_q + CNT_W'(1) == count_q) begin
          state_d = S_DIV_GO;
        end else begin
          state_d = S_USE_RD;
        end
      end

      S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end

      S_DIV_WAIT: begin
        if (div_done) begin
          usage_d = div_quot;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // start the usage walk
    if (enter_use) begin
      idx_d      = '0;
      used_sum_d = '0;
      all_sum_d  = '0;
      state_d    = S_USE_RD;
    end

    // a write to entry 0 ends the rebuilt-table override
    if (mem_we && (mem_waddr == '0)) begin
      init_d = 1'b0;
    end
  end

  assign busy_o           = (state_q != S_IDLE);
  assign result_valid_o   = valid_q;
  assign status_o         = status_q;
  assign granted_offset_o = granted_q;
  assign usage_percent_o  = usage_q;

endmodule

/* hdl/ffsa_checker.sv */
// port-level checks for the first-fit segment allocator
module ffsa_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        result_valid_o,
  input logic [1:0]                  status_o,
  input logic [ffsa_pkg::SIZE_W-1:0] granted_offset_o,
  input logic [ffsa_pkg::PCT_W-1:0]  usage_percent_o
);
  import ffsa_pkg::*;

  // an accepted request keeps the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after request");

  // a result strobe lasts one cycle
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // only a successful request can grant a nonzero offset
  a_grant_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != ST_OK) |-> granted_offset_o == '0)
    else $error("offset granted on failed request");

  // percentage stays in range
  a_usage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> usage_percent_o <= 7'd100)
    else $error("usage above 100 percent");

  // result appears only when the block has finished
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result while busy");

endmodule

bind first_fit_segment_allocator_core ffsa_checker u_ffsa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .result_valid_o   (result_valid_o),
  .status_o         (status_o),
  .granted_offset_o (granted_offset_o),
  .usage_percent_o  (usage_percent_o)
);
